FILE: hw/rtl/key_group_debounce_event_mapper_assert.svh
// Assertion helpers for the key group debounce block.
// Both expect clk_i in the scope of use; KGDM_ASSERT also expects rst_ni.
`ifndef KEY_GROUP_DEBOUNCE_EVENT_MAPPER_ASSERT_SVH
`define KEY_GROUP_DEBOUNCE_EVENT_MAPPER_ASSERT_SVH

// Check while out of reset.
`define KGDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define KGDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/kgdm_pkg.sv
package kgdm_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned NumEv    = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgW-1:0] DebounceTimeRst  = 16'd30;
  localparam logic [CfgW-1:0] LongPressTimeRst = 16'd800;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgDebounceTime  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPressTime = 8'd1;

  // Key bit positions.
  localparam int unsigned KeyK1 = 0;
  localparam int unsigned KeyK2 = 1;
  localparam int unsigned KeyK3 = 2;

  // Pending flag / counter positions.
  localparam int unsigned FlagK1Short = 0;
  localparam int unsigned FlagK1Long  = 1;
  localparam int unsigned FlagK2Short = 2;
  localparam int unsigned FlagK3Short = 3;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvK1Short = 3'd1,
    EvK1Long  = 3'd2,
    EvK2Short = 3'd3,
    EvK3Short = 3'd4
  } ev_code_e;

endpackage

FILE: hw/rtl/kgdm_intf.sv
interface kgdm_poll_if;
  logic                      valid;
  logic                      ready;
  logic                      tick;
  logic [kgdm_pkg::KeyW-1:0] raw_keys;
  logic                      pop_request;

  modport source (output valid, tick, raw_keys, pop_request, input ready);
  modport sink   (input valid, tick, raw_keys, pop_request, output ready);
endinterface

interface kgdm_event_if;
  logic                       valid;
  logic                       ready;
  logic                       event_valid;
  logic [2:0]                 event_code;
  logic [kgdm_pkg::NumEv-1:0] pending_flags;
  logic [kgdm_pkg::KeyW-1:0]  stable_keys;
  logic                       long_active;
  logic [kgdm_pkg::CntW-1:0]  k1_short_total;
  logic [kgdm_pkg::CntW-1:0]  k1_long_total;
  logic [kgdm_pkg::CntW-1:0]  k2_short_total;
  logic [kgdm_pkg::CntW-1:0]  k3_short_total;
  logic [kgdm_pkg::TimeW-1:0] time_ms;

  modport source (output valid, event_valid, event_code, pending_flags, stable_keys,
                  long_active, k1_short_total, k1_long_total, k2_short_total,
                  k3_short_total, time_ms, input ready);
  modport sink   (input valid, event_valid, event_code, pending_flags, stable_keys,
                  long_active, k1_short_total, k1_long_total, k2_short_total,
                  k3_short_total, time_ms, output ready);
endinterface

interface kgdm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kgdm_pkg::CfgIdxW-1:0]  index;
  logic [kgdm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/key_group_debounce_event_mapper.sv
// Channel  | Dir | Payload                                   | Beat when
// ---------+-----+-------------------------------------------+------------------
// poll_i   | in  | tick, raw_keys, pop_request               | valid && ready
// event_o  | out | event_valid/code, flags, keys, totals,time| valid && ready
// cfg_i    | in  | index, data (debounce / long press time)  | valid && ready
//
// One poll per clock sustained while event_o is ready. A poll's result passes the
// input register, then the result register, before it is offered on event_o.
// Debounce and long press checks (32-bit subtract and compare) sit between the two.
// Reset clears the block state (keys released, totals and time zero), timing to 30/800 ms.
// A stalled event_o holds its beat; one more poll waits in the input register,
// then poll_i.ready drops. cfg_i is always ready.

`include "key_group_debounce_event_mapper_assert.svh"

module key_group_debounce_event_mapper (
  input  logic clk_i,
  input  logic rst_ni,
  kgdm_poll_if.sink    poll_i,
  kgdm_event_if.source event_o,
  kgdm_cfg_if.sink     cfg_i
);

  // Configuration registers
  logic [kgdm_pkg::CfgW-1:0] debounce_time_q, long_press_time_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_time_q   <= kgdm_pkg::DebounceTimeRst;
      long_press_time_q <= kgdm_pkg::LongPressTimeRst;
    end else if (cfg_i.valid) begin
      // Writes beyond the register list are dropped.
      if (cfg_i.index == kgdm_pkg::CfgDebounceTime) begin
        debounce_time_q <= cfg_i.data;
      end else if (cfg_i.index == kgdm_pkg::CfgLongPressTime) begin
        long_press_time_q <= cfg_i.data;
      end
    end
  end

  // Input register
  logic                      s1_valid_q;
  logic                      s1_tick_q;
  logic [kgdm_pkg::KeyW-1:0] s1_raw_q;
  logic                      s1_pop_q;
  logic                      out_valid_q;
  logic                      advance;
  logic                      fire;

  // Result register is free, or its beat leaves this cycle.
  assign advance      = !out_valid_q || event_o.ready;
  assign fire         = s1_valid_q && advance;
  assign poll_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      s1_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.ready && poll_i.valid) begin
      s1_tick_q <= poll_i.tick;
      s1_raw_q  <= poll_i.raw_keys;
      s1_pop_q  <= poll_i.pop_request;
    end
  end

  // Block state
  logic [kgdm_pkg::TimeW-1:0] ms_q, ms_d;
  logic [kgdm_pkg::KeyW-1:0]  last_raw_q;
  logic [kgdm_pkg::TimeW-1:0] rct_q, rct_d;
  logic [kgdm_pkg::KeyW-1:0]  deb_q, deb_d;
  logic [kgdm_pkg::KeyW-1:0]  acc_q, acc_d;
  logic                       locked_q, locked_d;
  logic                       lrep_q, lrep_d;
  logic [kgdm_pkg::TimeW-1:0] pst_q, pst_d;
  logic [kgdm_pkg::NumEv-1:0] pend_q, pend_d;
  logic [kgdm_pkg::CntW-1:0]  cnt_q [kgdm_pkg::NumEv];
  logic                       ev_valid_q, ev_valid_d;
  kgdm_pkg::ev_code_e         ev_code_q, ev_code_d;

  logic                       raw_changed;
  logic [kgdm_pkg::TimeW-1:0] deb_age, press_age;
  logic                       deb_take, press, release_grp, long_hit;
  logic [kgdm_pkg::NumEv-1:0] raise, pend_raised;

  always_comb begin
    ms_d        = ms_q + {{(kgdm_pkg::TimeW-1){1'b0}}, s1_tick_q};
    raw_changed = (s1_raw_q != last_raw_q);
    rct_d       = raw_changed ? ms_d : rct_q;
    // A fresh raw change has age zero.
    deb_age     = raw_changed ? '0 : (ms_d - rct_q);
    deb_take    = (s1_raw_q != deb_q) &&
                  (deb_age >= {{(kgdm_pkg::TimeW-kgdm_pkg::CfgW){1'b0}}, debounce_time_q});
    deb_d       = deb_take ? s1_raw_q : deb_q;
    press       = deb_take && (deb_q == '0) && (s1_raw_q != '0);
    release_grp = deb_take && (deb_q != '0) && (s1_raw_q == '0);

    raise    = '0;
    locked_d = locked_q;
    acc_d    = acc_q;
    lrep_d   = lrep_q;
    pst_d    = pst_q;

    if (press) begin
      locked_d = 1'b1;
      acc_d    = s1_raw_q;
      pst_d    = ms_d;
      lrep_d   = 1'b0;
      raise[kgdm_pkg::FlagK2Short] = s1_raw_q[kgdm_pkg::KeyK2];
      raise[kgdm_pkg::FlagK3Short] = s1_raw_q[kgdm_pkg::KeyK3];
    end else if (release_grp) begin
      // K1 short only if no long event came during this press.
      raise[kgdm_pkg::FlagK1Short] = locked_q && acc_q[kgdm_pkg::KeyK1] && !lrep_q;
      locked_d = 1'b0;
      acc_d    = '0;
      lrep_d   = 1'b0;
      pst_d    = '0;
    end

    // Hold time of K1; zero in the press poll itself.
    press_age = press ? '0 : (ms_d - pst_q);
    long_hit  = locked_d && acc_d[kgdm_pkg::KeyK1] && deb_d[kgdm_pkg::KeyK1] && !lrep_d &&
                (press_age >= {{(kgdm_pkg::TimeW-kgdm_pkg::CfgW){1'b0}}, long_press_time_q});
    if (long_hit) begin
      lrep_d = 1'b1;
      raise[kgdm_pkg::FlagK1Long] = 1'b1;
    end

    pend_raised = pend_q | raise;
    pend_d      = pend_raised;
    ev_valid_d  = 1'b0;
    ev_code_d   = kgdm_pkg::EvNone;
    // Pop the lowest flag first.
    if (s1_pop_q) begin
      priority if (pend_raised[kgdm_pkg::FlagK1Short]) begin
        pend_d[kgdm_pkg::FlagK1Short] = 1'b0;
        ev_valid_d = 1'b1;
        ev_code_d  = kgdm_pkg::EvK1Short;
      end else if (pend_raised[kgdm_pkg::FlagK1Long]) begin
        pend_d[kgdm_pkg::FlagK1Long] = 1'b0;
        ev_valid_d = 1'b1;
        ev_code_d  = kgdm_pkg::EvK1Long;
      end else if (pend_raised[kgdm_pkg::FlagK2Short]) begin
        pend_d[kgdm_pkg::FlagK2Short] = 1'b0;
        ev_valid_d = 1'b1;
        ev_code_d  = kgdm_pkg::EvK2Short;
      end else if (pend_raised[kgdm_pkg::FlagK3Short]) begin
        pend_d[kgdm_pkg::FlagK3Short] = 1'b0;
        ev_valid_d = 1'b1;
        ev_code_d  = kgdm_pkg::EvK3Short;
      end else begin
        ev_valid_d = 1'b0;
      end
    end
  end

  // State advances only when a result is loaded, so the state registers
  // themselves carry the result fields of the beat on event_o.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q        <= '0;
      last_raw_q  <= '0;
      rct_q       <= '0;
      deb_q       <= '0;
      acc_q       <= '0;
      locked_q    <= 1'b0;
      lrep_q      <= 1'b0;
      pst_q       <= '0;
      pend_q      <= '0;
      ev_valid_q  <= 1'b0;
      ev_code_q   <= kgdm_pkg::EvNone;
    end else if (fire) begin
      ms_q        <= ms_d;
      last_raw_q  <= s1_raw_q;
      rct_q       <= rct_d;
      deb_q       <= deb_d;
      acc_q       <= acc_d;
      locked_q    <= locked_d;
      lrep_q      <= lrep_d;
      pst_q       <= pst_d;
      pend_q      <= pend_d;
      ev_valid_q  <= ev_valid_d;
      ev_code_q   <= ev_code_d;
    end
  end

  // Event counters wrap.
  for (genvar g = 0; g < kgdm_pkg::NumEv; g++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[g] <= '0;
      end else if (fire && raise[g]) begin
        cnt_q[g] <= cnt_q[g] + {{(kgdm_pkg::CntW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  assign event_o.valid          = out_valid_q;
  assign event_o.event_valid    = ev_valid_q;
  assign event_o.event_code     = ev_code_q;
  assign event_o.pending_flags  = pend_q;
  assign event_o.stable_keys    = deb_q;
  assign event_o.long_active    = lrep_q;
  assign event_o.k1_short_total = cnt_q[kgdm_pkg::FlagK1Short];
  assign event_o.k1_long_total  = cnt_q[kgdm_pkg::FlagK1Long];
  assign event_o.k2_short_total = cnt_q[kgdm_pkg::FlagK2Short];
  assign event_o.k3_short_total = cnt_q[kgdm_pkg::FlagK3Short];
  assign event_o.time_ms        = ms_q;

  `KGDM_ASSERT_ALWAYS(a_lock_tracks_mask, locked_q == (acc_q != '0), "lock and mask disagree")
  `KGDM_ASSERT_ALWAYS(a_lock_tracks_stable, locked_q == (deb_q != '0), "lock without keys")
  `KGDM_ASSERT_ALWAYS(a_long_needs_k1, lrep_q |-> locked_q && acc_q[kgdm_pkg::KeyK1], "no K1")
  `KGDM_ASSERT(a_hold_poll, (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_raw_q)), "poll lost")
  `KGDM_ASSERT(a_pop_code, (out_valid_q && ev_valid_q) |-> (ev_code_q != kgdm_pkg::EvNone), "pop without code")

endmodule
